// ===== design/erpv_pkg.sv =====
// ----------------------------------------------------------------------------
// erpv_pkg
// Shared types, constants and helper functions for the vertex rotate and
// project unit: quarter-wave sine table, angle folding, divide by 10000.
// ----------------------------------------------------------------------------
package erpv_pkg;

    localparam int TRIG_W = 15;                  // signed sine/cosine, +-10000
    typedef logic signed [TRIG_W-1:0] t_trig;

    localparam int Q10K_W = 17;                  // quotient of a 30-bit value by 10000
    localparam int DEN_W  = 18;                  // perspective divisor magnitude

    // Reciprocal of 10000: floor(n * RECIP_10K / 2^44) == n / 10000 for n < 2^30.
    localparam logic [30:0] RECIP_10K = 31'd1759218605;
    localparam int          RECIP_SH  = 44;
    localparam logic [13:0] SCALE     = 14'd10000;

    // Register indexes on the config port
    localparam logic [1:0] CFG_DEPTH    = 2'd0;
    localparam logic [1:0] CFG_CENTRE_X = 2'd1;
    localparam logic [1:0] CFG_CENTRE_Y = 2'd2;

    localparam logic [13:0] SINE_TAB [0:90] = '{
        14'd0,    14'd174,  14'd348,  14'd523,  14'd697,  14'd871,  14'd1045, 14'd1218,
        14'd1391, 14'd1564, 14'd1736, 14'd1908, 14'd2079, 14'd2249, 14'd2419, 14'd2588,
        14'd2756, 14'd2923, 14'd3090, 14'd3255, 14'd3420, 14'd3583, 14'd3746, 14'd3907,
        14'd4067, 14'd4226, 14'd4383, 14'd4539, 14'd4694, 14'd4848, 14'd5000, 14'd5150,
        14'd5299, 14'd5446, 14'd5591, 14'd5735, 14'd5877, 14'd6018, 14'd6156, 14'd6293,
        14'd6427, 14'd6560, 14'd6691, 14'd6819, 14'd6946, 14'd7071, 14'd7193, 14'd7313,
        14'd7431, 14'd7547, 14'd7660, 14'd7771, 14'd7880, 14'd7986, 14'd8090, 14'd8191,
        14'd8290, 14'd8386, 14'd8480, 14'd8571, 14'd8660, 14'd8746, 14'd8829, 14'd8910,
        14'd8987, 14'd9063, 14'd9135, 14'd9205, 14'd9271, 14'd9335, 14'd9396, 14'd9455,
        14'd9510, 14'd9563, 14'd9612, 14'd9659, 14'd9702, 14'd9743, 14'd9781, 14'd9816,
        14'd9848, 14'd9876, 14'd9902, 14'd9925, 14'd9945, 14'd9961, 14'd9975, 14'd9986,
        14'd9993, 14'd9998, 14'd10000
    };

    // 360..511 fold once to 0..151
    function automatic logic [8:0] norm_angle(input logic [8:0] a);
        return (a >= 9'd360) ? (a - 9'd360) : a;
    endfunction

    function automatic t_trig tab(input logic [8:0] idx);
        return t_trig'({1'b0, SINE_TAB[idx[6:0]]});
    endfunction

    function automatic t_trig sine_of(input logic [8:0] v);
        if (v < 9'd181) begin
            return (v < 9'd91) ? tab(v) : tab(9'd180 - v);
        end
        return (v < 9'd271) ? -tab(v - 9'd180) : -tab(9'd360 - v);
    endfunction

    function automatic t_trig cosine_of(input logic [8:0] v);
        if (v < 9'd181) begin
            return (v < 9'd91) ? tab(9'd90 - v) : -tab(v - 9'd90);
        end
        return (v < 9'd271) ? -tab(9'd270 - v) : tab(v - 9'd270);
    endfunction

    // Unsigned n / 10000 by reciprocal multiply
    function automatic logic [Q10K_W-1:0] div10k(input logic [29:0] n);
        logic [60:0] p;
        p = 61'(n) * 61'(RECIP_10K);
        return p[60:RECIP_SH];
    endfunction

    // Signed x / 10000, truncating toward zero; |x| < 2^30
    function automatic logic signed [Q10K_W:0] sdiv10k(input logic signed [30:0] x);
        logic [30:0]       mag;
        logic [Q10K_W-1:0] q;
        mag = x[30] ? 31'(-x) : 31'(x);
        q   = div10k(mag[29:0]);
        return x[30] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

endpackage

// ===== design/erpv_div.sv =====
// ----------------------------------------------------------------------------
// erpv_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside each beat.
// ----------------------------------------------------------------------------
module erpv_div
    import erpv_pkg::*;
#(
    parameter int NUM_W = 19,
    parameter int SB_W  = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SB_W-1:0]   o_sb
);

    logic             r_vld [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [SB_W-1:0]  r_sb  [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             p_vld;
        logic [NUM_W-1:0] p_num, p_quo;
        logic [DEN_W-1:0] p_rem, p_den;
        logic [SB_W-1:0]  p_sb;
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_rem = '0;
            assign p_den = i_den;
            assign p_sb  = i_sb;
        end else begin : g_next
            assign p_vld = r_vld[s-1];
            assign p_num = r_num[s-1];
            assign p_quo = r_quo[s-1];
            assign p_rem = r_rem[s-1];
            assign p_den = r_den[s-1];
            assign p_sb  = r_sb[s-1];
        end

        always_comb begin
            trial = {p_rem, p_num[NUM_W-1]};
            take  = (trial >= {1'b0, p_den});
            n_rem = take ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[s] <= p_num << 1;
            r_quo[s] <= {p_quo[NUM_W-2:0], take};
            r_rem[s] <= n_rem;
            r_den[s] <= p_den;
            r_sb[s]  <= p_sb;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_sb    = r_sb[NUM_W-1];

endmodule

// ===== design/euler_rotate_project_vertex_unit.sv =====
// ----------------------------------------------------------------------------
// euler_rotate_project_vertex_unit
// Z-Y-X Euler rotation of one vertex followed by a perspective divide.
// ----------------------------------------------------------------------------
// Pipeline: ten stages of trig lookup, matrix build, rotate and scale, then one
//   restoring-divider stage per quotient bit (COORD_BITS + 9), then an output
//   register.
// Throughput: one vertex per cycle; busy never rises, o_valid cannot stall.
// Reset: i_rst_n synchronous, active low; clears all beat valids and loads
//   depth_offset=600, centre_x=80, centre_y=64.
module euler_rotate_project_vertex_unit
    import erpv_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command side
    input  logic                         start,
    output logic                         busy,
    input  logic [8:0]                   i_angle_x,
    input  logic [8:0]                   i_angle_y,
    input  logic [8:0]                   i_angle_z,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [11:0]                  i_cfg_data,
    // results
    output logic                         o_valid,
    output logic signed [19:0]           o_screen_x,
    output logic signed [19:0]           o_screen_y,
    output logic signed [24:0]           o_rotated_depth,
    output logic                         o_divide_fault
);

    localparam int M_W   = Q10K_W + 1;           // matrix entry, signed
    localparam int P_W   = M_W + COORD_BITS;     // entry * coordinate
    localparam int R_W   = COORD_BITS + 20;      // rotated coordinate, scale 10000
    localparam int NUM_W = COORD_BITS + 9;       // |r*256/10000|
    localparam int SB_W  = R_W + 2;              // {fault, sign, rz}

    // No back pressure anywhere: every beat moves one stage per cycle.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    logic [11:0] r_depth;
    logic [9:0]  r_centre_x, r_centre_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= 12'd600;
            r_centre_x <= 10'd80;
            r_centre_y <= 10'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEPTH:    r_depth    <= i_cfg_data;
                CFG_CENTRE_X: r_centre_x <= i_cfg_data[9:0];
                CFG_CENTRE_Y: r_centre_y <= i_cfg_data[9:0];
                default:      ;  // out of range: ignored
            endcase
        end
    end

    // ---------------- beat valids, stages 1..10 ----------------
    logic [10:1] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:1], start};
        end
    end

    // stage 1: fold angles, table lookup
    t_trig r1_sx, r1_cx, r1_sy, r1_cy, r1_sz, r1_cz;
    logic signed [COORD_BITS-1:0] r1_v [3];
    always_ff @(posedge i_clk) begin
        r1_sx   <= sine_of(norm_angle(i_angle_x));
        r1_cx   <= cosine_of(norm_angle(i_angle_x));
        r1_sy   <= sine_of(norm_angle(i_angle_y));
        r1_cy   <= cosine_of(norm_angle(i_angle_y));
        r1_sz   <= sine_of(norm_angle(i_angle_z));
        r1_cz   <= cosine_of(norm_angle(i_angle_z));
        r1_v[0] <= i_vertex_x;
        r1_v[1] <= i_vertex_y;
        r1_v[2] <= i_vertex_z;
    end

    // stage 2: first-level trig products
    logic signed [2*TRIG_W-1:0] r2_czcy, r2_szcy, r2_czsy, r2_szsy, r2_szcx;
    logic signed [2*TRIG_W-1:0] r2_cxcz, r2_sxcy, r2_szsx, r2_czsx, r2_cxcy;
    t_trig r2_sx, r2_cx, r2_sy;
    logic signed [COORD_BITS-1:0] r2_v [3];
    always_ff @(posedge i_clk) begin
        r2_czcy <= r1_cz * r1_cy;
        r2_szcy <= r1_sz * r1_cy;
        r2_czsy <= r1_cz * r1_sy;
        r2_szsy <= r1_sz * r1_sy;
        r2_szcx <= r1_sz * r1_cx;
        r2_cxcz <= r1_cx * r1_cz;
        r2_sxcy <= r1_sx * r1_cy;
        r2_szsx <= r1_sz * r1_sx;
        r2_czsx <= r1_cz * r1_sx;
        r2_cxcy <= r1_cx * r1_cy;
        r2_sx   <= r1_sx;
        r2_cx   <= r1_cx;
        r2_sy   <= r1_sy;
        r2_v    <= r1_v;
    end

    // stage 3: rescale by 10000
    logic signed [M_W-1:0] r3_m00, r3_m10, r3_czsy, r3_szsy, r3_szcx;
    logic signed [M_W-1:0] r3_cxcz, r3_m21, r3_szsx, r3_czsx, r3_m22, r3_m20;
    t_trig r3_sx, r3_cx;
    logic signed [COORD_BITS-1:0] r3_v [3];
    always_ff @(posedge i_clk) begin
        r3_m00  <= sdiv10k(31'(r2_czcy));
        r3_m10  <= sdiv10k(31'(r2_szcy));
        r3_czsy <= sdiv10k(31'(r2_czsy));
        r3_szsy <= sdiv10k(31'(r2_szsy));
        r3_szcx <= sdiv10k(31'(r2_szcx));
        r3_cxcz <= sdiv10k(31'(r2_cxcz));
        r3_m21  <= sdiv10k(31'(r2_sxcy));
        r3_szsx <= sdiv10k(31'(r2_szsx));
        r3_czsx <= sdiv10k(31'(r2_czsx));
        r3_m22  <= sdiv10k(31'(r2_cxcy));
        r3_m20  <= -M_W'(r2_sy);
        r3_sx   <= r2_sx;
        r3_cx   <= r2_cx;
        r3_v    <= r2_v;
    end

    // stage 4: second-level products for the mixed terms
    logic signed [M_W+TRIG_W-1:0] r4_a01, r4_a11, r4_a02, r4_a12;
    logic signed [M_W-1:0] r4_m00, r4_m10, r4_m20, r4_m21, r4_m22;
    logic signed [M_W-1:0] r4_szcx, r4_cxcz, r4_szsx, r4_czsx;
    logic signed [COORD_BITS-1:0] r4_v [3];
    always_ff @(posedge i_clk) begin
        r4_a01  <= r3_czsy * r3_sx;
        r4_a11  <= r3_szsy * r3_sx;
        r4_a02  <= r3_czsy * r3_cx;
        r4_a12  <= r3_szsy * r3_cx;
        r4_m00  <= r3_m00;
        r4_m10  <= r3_m10;
        r4_m20  <= r3_m20;
        r4_m21  <= r3_m21;
        r4_m22  <= r3_m22;
        r4_szcx <= r3_szcx;
        r4_cxcz <= r3_cxcz;
        r4_szsx <= r3_szsx;
        r4_czsx <= r3_czsx;
        r4_v    <= r3_v;
    end

    // stage 5: finish the matrix; m[row][col] with col = vertex component
    logic signed [M_W-1:0] r5_m [3][3];
    logic signed [COORD_BITS-1:0] r5_v [3];
    always_ff @(posedge i_clk) begin
        r5_m[0][0] <= r4_m00;
        r5_m[0][1] <= r4_m10;
        r5_m[0][2] <= r4_m20;
        r5_m[1][0] <= sdiv10k(31'(r4_a01)) - r4_szcx;
        r5_m[1][1] <= sdiv10k(31'(r4_a11)) + r4_cxcz;
        r5_m[1][2] <= r4_m21;
        r5_m[2][0] <= sdiv10k(31'(r4_a02)) + r4_szsx;
        r5_m[2][1] <= sdiv10k(31'(r4_a12)) - r4_czsx;
        r5_m[2][2] <= r4_m22;
        r5_v       <= r4_v;
    end

    // stage 6: nine entry * coordinate products
    logic signed [P_W-1:0] r6_p [3][3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r6_p[i][j] <= r5_m[i][j] * r5_v[j];
            end
        end
    end

    // stage 7: row sums -> rx, ry, rz
    logic signed [R_W-1:0] r7_r [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r7_r[i] <= R_W'(r6_p[i][0]) + R_W'(r6_p[i][1]) + R_W'(r6_p[i][2]);
        end
    end

    // stage 8: |r| / 10000
    logic              r8_neg [3];
    logic [29:0]       r8_mag [3];
    logic [Q10K_W-1:0] r8_qa  [3];
    logic signed [R_W-1:0] r8_rz;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r8_neg[i] <= r7_r[i][R_W-1];
            r8_mag[i] <= r7_r[i][R_W-1] ? 30'(-r7_r[i]) : 30'(r7_r[i]);
            r8_qa[i]  <= div10k(r7_r[i][R_W-1] ? 30'(-r7_r[i]) : 30'(r7_r[i]));
        end
        r8_rz <= r7_r[2];
    end

    // stage 9: remainders; perspective divisor rz/10000 + depth
    logic signed [Q10K_W+1:0] rzq, den;
    logic [29:0]              rem_full [2];
    always_comb begin
        rzq = r8_neg[2] ? -$signed({2'b0, r8_qa[2]}) : $signed({2'b0, r8_qa[2]});
        den = rzq + $signed({(Q10K_W-10)'(0), r_depth});
        for (int i = 0; i < 2; i++) begin
            rem_full[i] = r8_mag[i] - 30'(r8_qa[i] * SCALE);
        end
    end

    logic              r9_neg [2];
    logic [Q10K_W-1:0] r9_qa  [2];
    logic [13:0]       r9_rem [2];
    logic              r9_den_neg, r9_fault;
    logic [DEN_W-1:0]  r9_den_mag;
    logic signed [R_W-1:0] r9_rz;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r9_neg[i] <= r8_neg[i];
            r9_qa[i]  <= r8_qa[i];
            r9_rem[i] <= rem_full[i][13:0];
        end
        r9_den_neg <= den[Q10K_W+1];
        r9_den_mag <= den[Q10K_W+1] ? DEN_W'(-den) : den[DEN_W-1:0];
        r9_fault   <= (den == '0);
        r9_rz      <= r8_rz;
    end

    // stage 10: |r*256/10000| = qa*256 + (rem*256)/10000; quotient sign
    logic [NUM_W-1:0] r10_num [2];
    logic             r10_neg [2];
    logic [DEN_W-1:0] r10_den;
    logic             r10_fault;
    logic signed [R_W-1:0] r10_rz;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r10_num[i] <= NUM_W'({r9_qa[i], 8'b0}) + NUM_W'(div10k(30'({r9_rem[i], 8'b0})));
            r10_neg[i] <= r9_neg[i] ^ r9_den_neg;
        end
        r10_den   <= r9_den_mag;
        r10_fault <= r9_fault;
        r10_rz    <= r9_rz;
    end

    // ---------------- perspective divide ----------------
    logic             dx_valid, dy_valid;
    logic [NUM_W-1:0] dx_quo, dy_quo;
    logic [SB_W-1:0]  dx_sb;
    logic             dy_sb;

    erpv_div #(.NUM_W(NUM_W), .SB_W(SB_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[10]),
        .i_num   (r10_num[0]),
        .i_den   (r10_den),
        .i_sb    ({r10_fault, r10_neg[0], r10_rz}),
        .o_valid (dx_valid),
        .o_quo   (dx_quo),
        .o_sb    (dx_sb)
    );

    erpv_div #(.NUM_W(NUM_W), .SB_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[10]),
        .i_num   (r10_num[1]),
        .i_den   (r10_den),
        .i_sb    (r10_neg[1]),
        .o_valid (dy_valid),
        .o_quo   (dy_quo),
        .o_sb    (dy_sb)
    );

    // ---------------- output stage ----------------
    logic                       fault;
    logic signed [R_W-1:0]      rz_out;
    logic signed [NUM_W:0]      qx, qy;
    logic signed [NUM_W+11:0]   sx_full, sy_full;
    logic signed [R_W+24:0]     rz_wide;

    always_comb begin
        fault   = dx_sb[SB_W-1];
        rz_out  = dx_sb[R_W-1:0];
        qx      = dx_sb[R_W] ? -$signed({1'b0, dx_quo}) : $signed({1'b0, dx_quo});
        qy      = dy_sb ? -$signed({1'b0, dy_quo}) : $signed({1'b0, dy_quo});
        sx_full = (NUM_W+12)'(qx) + $signed({(NUM_W+2)'(0), r_centre_x});
        sy_full = (NUM_W+12)'(qy) + $signed({(NUM_W+2)'(0), r_centre_y});
        rz_wide = (R_W+25)'(rz_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dx_valid & dy_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_screen_x      <= fault ? '0 : sx_full[19:0];
        o_screen_y      <= fault ? '0 : sy_full[19:0];
        o_rotated_depth <= rz_wide[24:0];
        o_divide_fault  <= fault;
    end

endmodule

// ===== sim/euler_rotate_project_vertex_unit_tb.sv =====
// ----------------------------------------------------------------------------
// euler_rotate_project_vertex_unit_tb
// Self-checking bench for the vertex rotate/project unit. Commands go in as
// bursts with random gaps. Each result beat is checked field by field against
// a bit-exact model kept in the bench. The model follows the same truncating
// divide order and runs under several register settings, the extremes among
// them.
// ----------------------------------------------------------------------------
module euler_rotate_project_vertex_unit_tb;
    import erpv_pkg::*;

    localparam int CB         = 10;
    localparam int IDLE_LIMIT = 4000;    // cycles with no beat at all
    localparam int DRAIN_WAIT = 40;      // longer than the pipeline latency
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [19:0] sx;
        logic signed [19:0] sy;
        logic signed [24:0] depth;
        logic               fault;
    } t_proj;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [8:0]    i_angle_x = '0, i_angle_y = '0, i_angle_z = '0;
    logic signed [CB-1:0] i_vertex_x = '0, i_vertex_y = '0, i_vertex_z = '0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [11:0]   i_cfg_data = '0;
    logic          o_valid;
    logic signed [19:0] o_screen_x, o_screen_y;
    logic signed [24:0] o_rotated_depth;
    logic          o_divide_fault;

    // bench copy of the registers
    longint        depth_off = 600;
    longint        cen_x = 80;
    longint        cen_y = 64;

    t_proj         pending_proj[$];
    int            n_fail = 0;
    int            n_sent = 0;
    int            n_checked = 0;
    int            n_faults = 0;
    int            idle_cycles = 0;

    euler_rotate_project_vertex_unit #(.COORD_BITS(CB)) i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model
    function automatic longint fold_deg(input logic [8:0] a);
        return (a >= 9'd360) ? longint'(a) - 360 : longint'(a);
    endfunction

    function automatic longint qsin(input longint v);
        return longint'(SINE_TAB[v]);
    endfunction

    function automatic longint sin_deg(input longint v);
        if (v < 181) begin
            return (v < 91) ? qsin(v) : qsin(180 - v);
        end
        return (v < 271) ? -qsin(v - 180) : -qsin(360 - v);
    endfunction

    function automatic longint cos_deg(input longint v);
        if (v < 181) begin
            return (v < 91) ? qsin(90 - v) : -qsin(v - 90);
        end
        return (v < 271) ? -qsin(270 - v) : qsin(v - 270);
    endfunction

    // Z-Y-X rotate then perspective divide; all divides truncate toward zero
    function automatic t_proj project_vertex(input logic [8:0] ax, ay, az,
                                             input logic signed [CB-1:0] vx, vy, vz);
        longint sa, ca, sb, cb, sc, cc;
        longint m00, m10, m20, m01, m11, m21, m02, m12, m22;
        longint rx, ry, rz, dv, px, py;
        t_proj  r;
        sa = sin_deg(fold_deg(ax)); ca = cos_deg(fold_deg(ax));
        sb = sin_deg(fold_deg(ay)); cb = cos_deg(fold_deg(ay));
        sc = sin_deg(fold_deg(az)); cc = cos_deg(fold_deg(az));
        m00 = cc * cb / 10000;
        m10 = sc * cb / 10000;
        m20 = -sb;
        m01 = cc * sb / 10000 * sa / 10000 - sc * ca / 10000;
        m11 = sc * sb / 10000 * sa / 10000 + ca * cc / 10000;
        m21 = sa * cb / 10000;
        m02 = cc * sb / 10000 * ca / 10000 + sc * sa / 10000;
        m12 = sc * sb / 10000 * ca / 10000 - cc * sa / 10000;
        m22 = ca * cb / 10000;
        rx = m00 * vx + m10 * vy + m20 * vz;
        ry = m01 * vx + m11 * vy + m21 * vz;
        rz = m02 * vx + m12 * vy + m22 * vz;
        dv = rz / 10000 + depth_off;
        px = 0;
        py = 0;
        if (dv != 0) begin
            px = (rx * 256) / 10000 / dv + cen_x;
            py = (ry * 256) / 10000 / dv + cen_y;
        end
        r.sx    = px[19:0];
        r.sy    = py[19:0];
        r.depth = rz[24:0];
        r.fault = (dv == 0);
        return r;
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_proj e;
        if (i_rst_n && o_valid) begin
            if (pending_proj.size() == 0) begin
                $display("%0t: unexpected result beat sx=%0d sy=%0d", $time,
                         o_screen_x, o_screen_y);
                n_fail++;
            end else begin
                e = pending_proj.pop_front();
                n_checked++;
                if (e.fault) n_faults++;
                if (o_screen_x !== e.sx) begin
                    $display("%0t: screen_x exp %0d got %0d", $time, e.sx, o_screen_x);
                    n_fail++;
                end
                if (o_screen_y !== e.sy) begin
                    $display("%0t: screen_y exp %0d got %0d", $time, e.sy, o_screen_y);
                    n_fail++;
                end
                if (o_rotated_depth !== e.depth) begin
                    $display("%0t: rotated_depth exp %0d got %0d", $time, e.depth,
                             o_rotated_depth);
                    n_fail++;
                end
                if (o_divide_fault !== e.fault) begin
                    $display("%0t: divide_fault exp %0b got %0b", $time, e.fault,
                             o_divide_fault);
                    n_fail++;
                end
            end
        end
    end

    // watchdog: any accepted beat clears it
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // one command beat; start stays high for the caller's next beat
    task automatic send_vertex(input logic [8:0] ax, ay, az,
                               input logic signed [CB-1:0] vx, vy, vz);
        start      <= 1'b1;
        i_angle_x  <= ax;
        i_angle_y  <= ay;
        i_angle_z  <= az;
        i_vertex_x <= vx;
        i_vertex_y <= vy;
        i_vertex_z <= vz;
        do @(posedge i_clk); while (busy);
        pending_proj.push_back(project_vertex(ax, ay, az, vx, vy, vz));
        n_sent++;
    endtask

    task automatic pause_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for every result, then out past the pipeline
    task automatic drain;
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_proj.size() != 0 && guard < IDLE_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unique case (idx)
            CFG_DEPTH:    depth_off = longint'(data);
            CFG_CENTRE_X: cen_x = longint'(data[9:0]);
            CFG_CENTRE_Y: cen_y = longint'(data[9:0]);
            default: ;   // unused index: write dropped
        endcase
    endtask

    task automatic set_view(input logic [11:0] d, cx, cy);
        drain();
        write_reg(CFG_DEPTH, d);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
    endtask

    // random burst stream, mostly legal angles, some above 359
    task automatic random_burst_stream(input int count);
        int left;
        logic [8:0] a0, a1, a2;
        left = 0;
        for (int k = 0; k < count; k++) begin
            if (left == 0) begin
                left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) == 0) pause_cycles($urandom_range(1, 15));
            end
            left--;
            if ($urandom_range(0, 7) == 0) begin
                a0 = 9'($urandom); a1 = 9'($urandom); a2 = 9'($urandom);
            end else begin
                a0 = 9'($urandom_range(0, 359));
                a1 = 9'($urandom_range(0, 359));
                a2 = 9'($urandom_range(0, 359));
            end
            send_vertex(a0, a1, a2, CB'($urandom), CB'($urandom), CB'($urandom));
            if (k == count / 2) drain();   // let the pipe run dry once
        end
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_reset_view;
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd0, 10'sd0, 10'sd0);
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd511, 10'sd511, 10'sd511);
        send_vertex(9'd0, 9'd0, 9'd0, -10'sd512, -10'sd512, -10'sd512);
        send_vertex(9'd45, 9'd30, 9'd60, 10'sd100, -10'sd200, 10'sd300);
    endtask

    task automatic test_angle_extremes;
        logic [8:0] angs [9] = '{9'd0, 9'd90, 9'd91, 9'd180, 9'd181, 9'd270,
                                 9'd359, 9'd360, 9'd511};
        foreach (angs[k]) begin
            send_vertex(angs[k], angs[(k + 3) % 9], angs[(k + 6) % 9],
                        10'sd511, -10'sd512, 10'sd257);
        end
        pause_cycles(3);
        send_vertex(9'd511, 9'd511, 9'd511, -10'sd512, 10'sd511, -10'sd1);
    endtask

    // zero divisor: rz/10000 cancels the depth offset exactly
    task automatic test_divide_fault;
        set_view(12'd500, 12'd80, 12'd64);
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd37, 10'sd12, -10'sd500);
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd0, 10'sd0, 10'sd500);    // divisor 1000
        set_view(12'd0, 12'd1023, 12'd1023);
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd300, -10'sd300, 10'sd0); // divisor zero
        send_vertex(9'd0, 9'd0, 9'd0, 10'sd300, -10'sd300, -10'sd1);
        send_vertex(9'd180, 9'd0, 9'd0, 10'sd511, 10'sd511, 10'sd511);
    endtask

    // unused index must leave every register alone; upper data bits on centres
    task automatic test_register_writes;
        drain();
        write_reg(CFG_UNUSED, 12'hFFF);
        write_reg(CFG_CENTRE_X, 12'hC05);
        write_reg(CFG_CENTRE_Y, 12'hA3F);
        send_vertex(9'd10, 9'd20, 9'd30, 10'sd5, 10'sd6, 10'sd7);
        send_vertex(9'd200, 9'd300, 9'd100, -10'sd5, 10'sd60, -10'sd70);
    endtask

    task automatic test_random_views;
        set_view(12'd600, 12'd80, 12'd64);
        random_burst_stream(220);
        set_view(12'd0, 12'd0, 12'd0);
        random_burst_stream(200);
        set_view(12'd4095, 12'd1023, 12'd1023);
        random_burst_stream(200);
        set_view(12'd1, 12'd512, 12'd3);
        random_burst_stream(200);
        set_view(12'($urandom), 12'($urandom), 12'($urandom));
        random_burst_stream(200);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_view();
        test_angle_extremes();
        test_divide_fault();
        test_register_writes();
        test_random_views();
        drain();
        $display("Sent %0d vertices, checked %0d results (%0d divide faults)",
                 n_sent, n_checked, n_faults);
        $display("Covered angle folding, all quadrants, zero divisor, five views");
        if (n_fail == 0 && pending_proj.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
